@@ hw/rtl/ptw_pkg.sv @@
package ptw_pkg;

    localparam int unsigned PA_W    = 52;
    localparam int unsigned VA_W    = 48;
    localparam int unsigned PTE_W   = 64;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned IDX_W   = 9;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

    localparam int unsigned PTE_PRESENT = 0;
    localparam int unsigned PTE_PS      = 7;

    typedef struct packed {
        logic               walking;
        logic [LEVEL_W-1:0] level;
        logic [VA_W-1:0]    vaddr;
    } t_walk_state;

    typedef struct packed {
        logic            valid;
        logic            kind;
        logic [PA_W-1:0] address;
        logic            fault;
        logic            large_page;
    } t_result;

endpackage

@@ hw/rtl/ptw_step.sv @@
module ptw_step (
    input  logic                        i_operation,
    input  logic [ptw_pkg::PA_W-1:0]    i_table_root,
    input  logic [ptw_pkg::VA_W-1:0]    i_virtual_address,
    input  logic [ptw_pkg::PTE_W-1:0]   i_read_data,
    input  ptw_pkg::t_walk_state        i_state,
    output ptw_pkg::t_walk_state        o_state,
    output ptw_pkg::t_result            o_result
);

    logic [ptw_pkg::VA_W-1:0]  va;
    logic [ptw_pkg::LEVEL_W-1:0] lvl;
    logic [ptw_pkg::IDX_W-1:0] idx;
    logic [ptw_pkg::PA_W-1:0]  base;

    always_comb begin
        if (i_operation == ptw_pkg::OP_START) begin
            va   = i_virtual_address;
            lvl  = ptw_pkg::LVL_PML4;
            base = i_table_root;
        end else begin
            va   = i_state.vaddr;
            lvl  = i_state.level + 2'd1;
            base = i_read_data[ptw_pkg::PA_W-1:0];
        end
    end

    always_comb begin
        case (lvl)
            ptw_pkg::LVL_PML4: idx = va[47:39];
            ptw_pkg::LVL_PDPT: idx = va[38:30];
            ptw_pkg::LVL_PD:   idx = va[29:21];
            ptw_pkg::LVL_PT:   idx = va[20:12];
            default:           idx = va[47:39];
        endcase
    end

    always_comb begin
        o_state             = i_state;
        o_result.valid      = 1'b1;
        o_result.kind       = ptw_pkg::KIND_READ;
        o_result.address    = {base[51:12], idx, 3'b000};
        o_result.fault      = 1'b0;
        o_result.large_page = 1'b0;
        if (i_operation == ptw_pkg::OP_START) begin
            o_state.walking = 1'b1;
            o_state.level   = ptw_pkg::LVL_PML4;
            o_state.vaddr   = i_virtual_address;
        end else if (!i_state.walking) begin
            o_result.valid = 1'b0;
        end else if (!i_read_data[ptw_pkg::PTE_PRESENT]) begin
            o_state.walking  = 1'b0;
            o_state.level    = ptw_pkg::LVL_PML4;
            o_result.kind    = ptw_pkg::KIND_DONE;
            o_result.address = '0;
            o_result.fault   = 1'b1;
        end else if (i_state.level == ptw_pkg::LVL_PD && i_read_data[ptw_pkg::PTE_PS]) begin
            o_state.walking     = 1'b0;
            o_state.level       = ptw_pkg::LVL_PML4;
            o_result.kind       = ptw_pkg::KIND_DONE;
            o_result.address    = {i_read_data[51:21], i_state.vaddr[20:0]};
            o_result.large_page = 1'b1;
        end else if (i_state.level == ptw_pkg::LVL_PT) begin
            o_state.walking  = 1'b0;
            o_state.level    = ptw_pkg::LVL_PML4;
            o_result.kind    = ptw_pkg::KIND_DONE;
            o_result.address = {i_read_data[51:12], i_state.vaddr[11:0]};
        end else begin
            o_state.level = lvl;
        end
    end

endmodule

@@ hw/rtl/four_level_page_table_walker_unit.sv @@
// Path: an accepted item passes through the input register, then the result
//   register; a response while idle gives no result.
// Throughput: one item per cycle while the output is not stalled.
// Reset: synchronous, active low; clears both valid flags and leaves the walker
//   idle at the top level with a zero saved address.
module four_level_page_table_walker_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_operation,
    input  logic [ptw_pkg::PA_W-1:0]  i_table_root,
    input  logic [ptw_pkg::VA_W-1:0]  i_virtual_address,
    input  logic [ptw_pkg::PTE_W-1:0] i_read_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_kind,
    output logic [ptw_pkg::PA_W-1:0]  o_address,
    output logic                      o_fault,
    output logic                      o_large_page
);

    logic                      r_in_valid;
    logic                      r_operation;
    logic [ptw_pkg::PA_W-1:0]  r_table_root;
    logic [ptw_pkg::VA_W-1:0]  r_virtual_address;
    logic [ptw_pkg::PTE_W-1:0] r_read_data;

    ptw_pkg::t_walk_state r_state;
    ptw_pkg::t_walk_state n_state;
    ptw_pkg::t_result     n_result;

    logic            r_out_valid;
    logic            r_kind;
    logic [ptw_pkg::PA_W-1:0] r_address;
    logic            r_fault;
    logic            r_large_page;

    logic advance;

    ptw_step u_step (
        .i_operation       (r_operation),
        .i_table_root      (r_table_root),
        .i_virtual_address (r_virtual_address),
        .i_read_data       (r_read_data),
        .i_state           (r_state),
        .o_state           (n_state),
        .o_result          (n_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready || !n_result.valid);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_operation       <= i_operation;
            r_table_root      <= i_table_root;
            r_virtual_address <= i_virtual_address;
            r_read_data       <= i_read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.valid) begin
            r_kind       <= n_result.kind;
            r_address    <= n_result.address;
            r_fault      <= n_result.fault;
            r_large_page <= n_result.large_page;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_address    = r_address;
    assign o_fault      = r_fault;
    assign o_large_page = r_large_page;

endmodule
